FILE: rtl/lrc_pkg.sv
package lrc_pkg;

    localparam int COORD_BITS = 11;
    localparam int ERR_BITS = COORD_BITS + 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef struct packed {
        logic req_type;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } t_in_beat;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic pixel_valid;
        logic last_pixel;
    } t_out_beat;

    // classified request as it travels from front to back
    typedef struct packed {
        logic is_step;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic dir_x_negative;
        logic dir_y_negative;
        logic x_is_major;
        logic signed [ERR_BITS-1:0] error_init;
        logic signed [ERR_BITS-1:0] diag_increment;
        logic signed [ERR_BITS-1:0] straight_increment;
        logic [COORD_BITS-1:0] steps;
    } t_cmd;

    function automatic logic [COORD_BITS-1:0] move_coord(
        input logic [COORD_BITS-1:0] c,
        input logic negative
    );
        return negative ? c - COORD_BITS'(1) : c + COORD_BITS'(1);
    endfunction

endpackage

FILE: rtl/line_rasterizer_core.sv
// Bresenham line rasterizer, all octants. Every input beat gives exactly one
// output beat: a start request returns the start pixel (last_pixel set for a
// zero-length line), a step request returns the next pixel of the line, and a
// step with no active line returns a beat with pixel_valid low and zero fields.
// A start request drops any line in progress. While neither side stalls, the
// block takes one beat per clock and returns one per clock. The front end sets
// up deltas, directions and error terms in the cycle of acceptance and writes
// them into a QUEUE_DEPTH-entry queue; unless the output stalls, the back end
// steps one pixel per cycle from that queue into a single output register, so
// up to QUEUE_DEPTH + 1 requests can be in flight while the output side stalls
// before the input side stalls in turn.
module line_rasterizer_core
    import lrc_pkg::*;
#(
    parameter int QUEUE_DEPTH = lrc_pkg::QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;

    assign o_in_stall = queue_full;

    lrc_front u_front (
        .i_beat (i_in_data),
        .o_cmd  (front_cmd)
    );

    lrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_in_valid),
        .i_push_data (front_cmd),
        .o_full      (queue_full),
        .o_valid     (queue_valid),
        .o_data      (queue_cmd),
        .i_pop       (queue_pop)
    );

    lrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: rtl/lrc_front.sv
module lrc_front
    import lrc_pkg::*;
(
    input  t_in_beat i_beat,
    output t_cmd     o_cmd
);

    logic                  dir_x_neg;
    logic                  dir_y_neg;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic                  x_major;
    logic [COORD_BITS-1:0] major;
    logic [COORD_BITS-1:0] minor;
    logic [ERR_BITS-1:0]   minor2;
    logic [ERR_BITS-1:0]   major1;
    logic [ERR_BITS-1:0]   major2;

    always_comb begin
        dir_x_neg = i_beat.end_x < i_beat.start_x;
        dir_y_neg = i_beat.end_y < i_beat.start_y;
        dx = dir_x_neg ? i_beat.start_x - i_beat.end_x : i_beat.end_x - i_beat.start_x;
        dy = dir_y_neg ? i_beat.start_y - i_beat.end_y : i_beat.end_y - i_beat.start_y;
        // ties go to y-major
        x_major = dx > dy;
        major = x_major ? dx : dy;
        minor = x_major ? dy : dx;
        minor2 = {1'b0, minor, 1'b0};
        major1 = {2'b00, major};
        major2 = {1'b0, major, 1'b0};

        o_cmd.is_step = (i_beat.req_type == REQ_STEP);
        o_cmd.x = i_beat.start_x;
        o_cmd.y = i_beat.start_y;
        o_cmd.dir_x_negative = dir_x_neg;
        o_cmd.dir_y_negative = dir_y_neg;
        o_cmd.x_is_major = x_major;
        o_cmd.error_init = $signed(minor2 - major1);
        o_cmd.diag_increment = $signed(minor2 - major2);
        o_cmd.straight_increment = $signed(minor2);
        o_cmd.steps = major;
    end

endmodule

FILE: rtl/lrc_queue.sv
module lrc_queue
    import lrc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_data,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

    t_cmd r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic [PTR_BITS-1:0] n_wr_ptr;
    logic [PTR_BITS-1:0] n_rd_ptr;
    logic [CNT_BITS-1:0] n_count;
    logic                do_push;
    logic                do_pop;

    assign o_full = (r_count == FULL_COUNT);
    assign o_valid = (r_count != '0);
    assign o_data = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_BITS'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_BITS'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: rtl/lrc_back.sv
module lrc_back
    import lrc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    logic [COORD_BITS-1:0]      r_cur_x, n_cur_x;
    logic [COORD_BITS-1:0]      r_cur_y, n_cur_y;
    logic signed [ERR_BITS-1:0] r_err, n_err;
    logic signed [ERR_BITS-1:0] r_diag, n_diag;
    logic signed [ERR_BITS-1:0] r_straight, n_straight;
    logic [COORD_BITS-1:0]      r_steps, n_steps;
    logic                       r_dxn, n_dxn;
    logic                       r_dyn, n_dyn;
    logic                       r_x_major, n_x_major;
    logic                       r_active, n_active;
    logic                       r_out_valid, n_out_valid;
    t_out_beat                  r_out, n_out;
    logic                       pop;
    logic                       diag_move;

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;
    assign o_cmd_pop = pop;

    always_comb begin
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_err = r_err;
        n_diag = r_diag;
        n_straight = r_straight;
        n_steps = r_steps;
        n_dxn = r_dxn;
        n_dyn = r_dyn;
        n_x_major = r_x_major;
        n_active = r_active;
        n_out_valid = r_out_valid && i_out_stall;
        n_out = r_out;
        diag_move = !r_err[ERR_BITS-1];
        // output register frees up this cycle or is already empty
        pop = i_cmd_valid && (!r_out_valid || !i_out_stall);

        if (pop) begin
            n_out_valid = 1'b1;
            n_out = '0;
            if (!i_cmd.is_step) begin
                n_cur_x = i_cmd.x;
                n_cur_y = i_cmd.y;
                n_err = i_cmd.error_init;
                n_diag = i_cmd.diag_increment;
                n_straight = i_cmd.straight_increment;
                n_steps = i_cmd.steps;
                n_dxn = i_cmd.dir_x_negative;
                n_dyn = i_cmd.dir_y_negative;
                n_x_major = i_cmd.x_is_major;
                n_active = (i_cmd.steps != '0);
                n_out.pixel_x = i_cmd.x;
                n_out.pixel_y = i_cmd.y;
                n_out.pixel_valid = 1'b1;
                n_out.last_pixel = (i_cmd.steps == '0);
            end else if (r_active) begin
                if (r_x_major) begin
                    n_cur_x = move_coord(r_cur_x, r_dxn);
                    if (diag_move) begin
                        n_cur_y = move_coord(r_cur_y, r_dyn);
                    end
                end else begin
                    n_cur_y = move_coord(r_cur_y, r_dyn);
                    if (diag_move) begin
                        n_cur_x = move_coord(r_cur_x, r_dxn);
                    end
                end
                n_err = r_err + (diag_move ? r_diag : r_straight);
                n_steps = r_steps - COORD_BITS'(1);
                n_active = (n_steps != '0);
                n_out.pixel_x = n_cur_x;
                n_out.pixel_y = n_cur_y;
                n_out.pixel_valid = 1'b1;
                n_out.last_pixel = !n_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x <= n_cur_x;
        r_cur_y <= n_cur_y;
        r_err <= n_err;
        r_diag <= n_diag;
        r_straight <= n_straight;
        r_steps <= n_steps;
        r_dxn <= n_dxn;
        r_dyn <= n_dyn;
        r_x_major <= n_x_major;
        r_out <= n_out;
    end

endmodule

FILE: tb/tb_line_rasterizer_core.sv
module tb_line_rasterizer_core;
    import lrc_pkg::*;

    localparam int COORD_MAX = (1 << COORD_BITS) - 1;
    localparam int HOLD_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS = 240;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_data;

    line_rasterizer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    t_in_beat  pending_reqs[$];
    t_out_beat pixels_due[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    logic hold_request = 1'b0;

    int mismatches = 0;
    int reqs_sent = 0;
    int lines_started = 0;
    int pixels_seen = 0;
    int line_ends_seen = 0;
    int idle_results_seen = 0;

    // rasterizer state as predicted
    logic [COORD_BITS-1:0] pos_x = '0;
    logic [COORD_BITS-1:0] pos_y = '0;
    logic [COORD_BITS-1:0] steps_to_go = '0;
    int err_acc = 0;
    int diag_step = 0;
    int flat_step = 0;
    logic neg_x = 1'b0;
    logic neg_y = 1'b0;
    logic x_major = 1'b0;
    logic drawing = 1'b0;

    function automatic t_out_beat trace_pixel(t_in_beat req);
        t_out_beat px;
        int dx;
        int dy;
        int major_d;
        int minor_d;
        logic diag;
        px = '0;
        if (req.req_type == REQ_START) begin
            neg_x = req.end_x < req.start_x;
            neg_y = req.end_y < req.start_y;
            dx = neg_x ? int'(req.start_x) - int'(req.end_x) : int'(req.end_x) - int'(req.start_x);
            dy = neg_y ? int'(req.start_y) - int'(req.end_y) : int'(req.end_y) - int'(req.start_y);
            // ties go to y-major
            x_major = dx > dy;
            major_d = x_major ? dx : dy;
            minor_d = x_major ? dy : dx;
            err_acc = 2 * minor_d - major_d;
            diag_step = 2 * (minor_d - major_d);
            flat_step = 2 * minor_d;
            steps_to_go = major_d[COORD_BITS-1:0];
            pos_x = req.start_x;
            pos_y = req.start_y;
            drawing = steps_to_go != '0;
            px.pixel_x = pos_x;
            px.pixel_y = pos_y;
            px.pixel_valid = 1'b1;
            px.last_pixel = !drawing;
        end else if (drawing) begin
            diag = err_acc >= 0;
            if (x_major) begin
                pos_x = neg_x ? pos_x - COORD_BITS'(1) : pos_x + COORD_BITS'(1);
                if (diag) pos_y = neg_y ? pos_y - COORD_BITS'(1) : pos_y + COORD_BITS'(1);
            end else begin
                pos_y = neg_y ? pos_y - COORD_BITS'(1) : pos_y + COORD_BITS'(1);
                if (diag) pos_x = neg_x ? pos_x - COORD_BITS'(1) : pos_x + COORD_BITS'(1);
            end
            err_acc += diag ? diag_step : flat_step;
            steps_to_go = steps_to_go - COORD_BITS'(1);
            drawing = steps_to_go != '0;
            px.pixel_x = pos_x;
            px.pixel_y = pos_y;
            px.pixel_valid = 1'b1;
            px.last_pixel = !drawing;
        end
        return px;
    endfunction

    // driver: request side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                pixels_due.push_back(trace_pixel(i_in_data));
                reqs_sent++;
                if (i_in_data.req_type == REQ_START) lines_started++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_data <= pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: pixel side
    int hold_left = 0;
    logic hold_done = 1'b0;
    t_out_beat want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (o_out_data.pixel_valid) pixels_seen++;
                else idle_results_seen++;
                if (o_out_data.last_pixel) line_ends_seen++;
                if (pixels_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: x=%0d y=%0d valid=%b last=%b",
                            o_out_data.pixel_x, o_out_data.pixel_y,
                            o_out_data.pixel_valid, o_out_data.last_pixel);
                end else begin
                    want = pixels_due.pop_front();
                    if (o_out_data.pixel_x !== want.pixel_x
                            || o_out_data.pixel_y !== want.pixel_y
                            || o_out_data.pixel_valid !== want.pixel_valid
                            || o_out_data.last_pixel !== want.last_pixel) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"pixel %0d: expected x=%0d y=%0d valid=%b last=%b,",
                                " got x=%0d y=%0d valid=%b last=%b"},
                                pixels_seen + idle_results_seen,
                                want.pixel_x, want.pixel_y, want.pixel_valid, want.last_pixel,
                                o_out_data.pixel_x, o_out_data.pixel_y,
                                o_out_data.pixel_valid, o_out_data.last_pixel);
                    end
                end
            end
            if (hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= $urandom_range(99) < stall_pct;
            end
        end
    end

    // watchdog: cycles with no beat on either side
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d pixels still due", pixels_due.size());
            $display("line_rasterizer_core: mismatch");
            $finish;
        end
    end

    task automatic push_start(int sx, int sy, int ex, int ey);
        t_in_beat b;
        b.req_type = REQ_START;
        b.start_x = sx[COORD_BITS-1:0];
        b.start_y = sy[COORD_BITS-1:0];
        b.end_x = ex[COORD_BITS-1:0];
        b.end_y = ey[COORD_BITS-1:0];
        pending_reqs.push_back(b);
    endtask

    // step requests carry random endpoint fields, which the block ignores
    task automatic push_steps(int n);
        t_in_beat b;
        for (int k = 0; k < n; k++) begin
            b.req_type = REQ_STEP;
            b.start_x = COORD_BITS'($urandom_range(COORD_MAX));
            b.start_y = COORD_BITS'($urandom_range(COORD_MAX));
            b.end_x = COORD_BITS'($urandom_range(COORD_MAX));
            b.end_y = COORD_BITS'($urandom_range(COORD_MAX));
            pending_reqs.push_back(b);
        end
    endtask

    function automatic int near_coord(int c, int spread);
        int v;
        v = c + int'($urandom_range(2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
        return v;
    endfunction

    // mostly whole lines with random content, some cut short or overrun, some noise
    task automatic queue_traffic(int count);
        int added;
        int roll;
        int sx;
        int sy;
        int ex;
        int ey;
        int spread;
        int adx;
        int ady;
        int major_len;
        int n_steps;
        t_in_beat b;
        added = 0;
        while (added < count) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                b.req_type = 1'($urandom_range(1));
                b.start_x = COORD_BITS'($urandom_range(COORD_MAX));
                b.start_y = COORD_BITS'($urandom_range(COORD_MAX));
                b.end_x = COORD_BITS'($urandom_range(COORD_MAX));
                b.end_y = COORD_BITS'($urandom_range(COORD_MAX));
                pending_reqs.push_back(b);
                added++;
            end else begin
                sx = $urandom_range(COORD_MAX);
                sy = $urandom_range(COORD_MAX);
                if (roll < 14) begin
                    // far endpoints, only the first few pixels before abandoning
                    ex = $urandom_range(COORD_MAX);
                    ey = $urandom_range(COORD_MAX);
                    n_steps = $urandom_range(8);
                end else begin
                    spread = ($urandom_range(39) == 0) ? 200 : 12;
                    ex = near_coord(sx, spread);
                    ey = ($urandom_range(5) == 0) ? near_coord(sy, 0) : near_coord(sy, spread);
                    adx = ex > sx ? ex - sx : sx - ex;
                    ady = ey > sy ? ey - sy : sy - ey;
                    major_len = adx > ady ? adx : ady;
                    roll = $urandom_range(9);
                    if (roll < 7) n_steps = major_len;
                    else if (roll < 9) n_steps = major_len + $urandom_range(1, 3);
                    else n_steps = $urandom_range(major_len);
                end
                push_start(sx, sy, ex, ey);
                push_steps(n_steps);
                added += 1 + n_steps;
            end
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || i_in_valid || pixels_due.size() > 0)
            @(negedge i_clk);
    endtask

    int idle_tab[4] = '{0, 52, 0, 30};
    int stall_tab[4] = '{0, 0, 52, 30};

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: idle step, zero-length line, tie, extremes, octants, abandon
        push_steps(1);
        push_start(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        push_steps(1);
        push_start(0, 0, 3, 3);
        push_steps(3);
        push_start(0, 0, COORD_MAX, 1);
        push_steps(2);
        push_start(COORD_MAX, COORD_MAX, 0, 0);
        push_steps(1);
        push_start(5, 9, 2, 10);
        push_steps(4);
        push_start(10, 5, 12, 0);
        push_steps(5);
        drain();

        // long receiver hold-off while requests keep coming
        hold_request = 1'b1;
        queue_traffic(80);
        drain();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_tab[p];
            stall_pct = stall_tab[p];
            queue_traffic(PHASE_ITEMS);
            drain();
        end

        repeat (8) @(negedge i_clk);
        $display("%0d requests (%0d line starts) gave %0d pixels, %0d line ends, %0d idle-step beats",
            reqs_sent, lines_started, pixels_seen, line_ends_seen, idle_results_seen);
        $display("covered all octants, ties, zero-length and abandoned lines, stalls both ways");
        if (mismatches == 0 && pixels_due.size() == 0) begin
            $display("line_rasterizer_core: match");
        end else begin
            $display("%0d mismatches, %0d pixels never arrived", mismatches, pixels_due.size());
            $display("line_rasterizer_core: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/lrc_pkg.sv
rtl/lrc_front.sv
rtl/lrc_queue.sv
rtl/lrc_back.sv
rtl/line_rasterizer_core.sv
tb/tb_line_rasterizer_core.sv
